@@ sv/rwcp_pkg.sv @@
`default_nettype none
package rwcp_pkg;

   localparam int ByteWidth      = 8;
   localparam int StatusWidth    = 3;
   localparam int CountWidth     = 16;
   localparam int RateWidth      = 32;
   localparam int FmtLen         = 16;
   localparam int FileHdrLen     = 12;
   localparam int ChunkHdrLen    = 8;

   localparam logic [31:0] TagRiff = 32'h5249_4646;
   localparam logic [31:0] TagWave = 32'h5741_5645;
   localparam logic [31:0] TagFmt  = 32'h666D_7420;
   localparam logic [31:0] TagData = 32'h6461_7461;

   localparam logic [CountWidth-1:0] DefaultChannels = 16'd1;
   localparam logic [RateWidth-1:0]  DefaultRate     = 32'd24000;
   localparam logic [CountWidth-1:0] DefaultBits     = 16'd16;

   localparam logic [StatusWidth-1:0] StatusOk      = 3'd0;
   localparam logic [StatusWidth-1:0] StatusShort   = 3'd1;
   localparam logic [StatusWidth-1:0] StatusNoRiff  = 3'd2;
   localparam logic [StatusWidth-1:0] StatusNoWave  = 3'd3;
   localparam logic [StatusWidth-1:0] StatusNoFmt   = 3'd4;
   localparam logic [StatusWidth-1:0] StatusNoData  = 3'd5;

   localparam logic KindSample  = 1'b0;
   localparam logic KindSummary = 1'b1;

   typedef struct packed {
      logic                   has_sample;
      logic                   has_summary;
      logic [ByteWidth-1:0]   sample_byte;
      logic                   run_start;
      logic                   parse_ok;
      logic [StatusWidth-1:0] status;
      logic [CountWidth-1:0]  channel_count;
      logic [RateWidth-1:0]   sampling_hz;
      logic [CountWidth-1:0]  sample_bits;
   } entry_type;

   function automatic logic [ByteWidth-1:0] tag_char(input logic [31:0] tag,
                                                     input logic [1:0] idx);
      logic [ByteWidth-1:0] ch;
      unique case (idx)
         2'd0: ch = tag[31:24];
         2'd1: ch = tag[23:16];
         2'd2: ch = tag[15:8];
         default: ch = tag[7:0];
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

@@ sv/rwcp_req_if.sv @@
`default_nettype none
interface rwcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       end_of_file;

   modport source (output valid, output file_byte, output end_of_file, input ready);
   modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface
`default_nettype wire

@@ sv/rwcp_rsp_if.sv @@
`default_nettype none
interface rwcp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  sample_byte;
   logic        run_start;
   logic        parse_ok;
   logic [2:0]  status;
   logic [15:0] channel_count;
   logic [31:0] sampling_hz;
   logic [15:0] sample_bits;

   modport source (output valid, output kind, output sample_byte, output run_start,
                   output parse_ok, output status, output channel_count,
                   output sampling_hz, output sample_bits, input ready);
   modport sink (input valid, input kind, input sample_byte, input run_start,
                 input parse_ok, input status, input channel_count,
                 input sampling_hz, input sample_bits, output ready);
endinterface
`default_nettype wire

@@ sv/riff_wave_chunk_parser_unit.sv @@
// Byte-serial WAV file parser.
// The req channel carries one file byte per transaction, with end_of_file set
// on the final byte. The rsp channel returns sample bytes of every data chunk
// (kind 0, run_start on the first byte of each chunk) and, after the final
// byte, one summary transaction (kind 1) with parse_ok, status and the format
// values of the last complete fmt block.
// A byte is parsed in the cycle it is accepted and its results sit in a
// two-entry result queue on the next cycle. Throughput is one byte per
// cycle while the queue is not full; the final byte of a file needs two rsp
// transactions when it also yields a sample. The queue absorbs the extra one
// because the next file starts with header bytes, unless that next byte ends
// a one-byte file; the byte after that one then waits for req ready.
// req ready depends only on the queue fill, never on rsp ready in the same
// cycle. When the receiver stalls, the queue fills and req ready drops after
// two pending entries. Reset, and the end of every file, return the parser to
// the file header state with default format values; reset also empties the
// queue.
`default_nettype none
module riff_wave_chunk_parser_unit
   import rwcp_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   rwcp_req_if.sink     req_if,
   rwcp_rsp_if.source   rsp_if
);

   localparam logic [1:0] PhFileHdr  = 2'd0;
   localparam logic [1:0] PhChunkHdr = 2'd1;
   localparam logic [1:0] PhBody     = 2'd2;
   localparam logic [1:0] PhIgnore   = 2'd3;

   localparam logic [1:0] ChunkOther   = 2'd0;
   localparam logic [1:0] ChunkFmt     = 2'd1;
   localparam logic [1:0] ChunkSamples = 2'd2;

   localparam logic [4:0] FmtWin = 5'(FmtLen);

   logic [1:0]            phase_ff, phase_in;
   logic [3:0]            hdr_index_ff, hdr_index_in;
   logic                  hdr_valid_ff, hdr_valid_in;
   logic                  riff_bad_ff, riff_bad_in;
   logic [31:0]           tag_ff, tag_in;
   logic [31:0]           size_ff, size_in;
   logic [32:0]           left_ff, left_in;
   logic                  first_ff, first_in;
   logic [1:0]            chunk_ff, chunk_in;
   logic [4:0]            win0_ff, win0_in;
   logic [4:0]            win1_ff, win1_in;
   logic [7:0]            scratch_ff [FmtLen];
   logic [7:0]            scratch_in [FmtLen];
   logic [15:0]           chan_ff, chan_in;
   logic [31:0]           rate_ff, rate_in;
   logic [15:0]           bits_ff, bits_in;
   logic                  seen_fmt_ff, seen_fmt_in;
   logic                  seen_data_ff, seen_data_in;

   entry_type             queue_ff [2];
   entry_type             entry_in;
   entry_type             head;
   logic                  rd_ptr_ff, wr_ptr_ff;
   logic [1:0]            count_ff, count_in;
   logic                  sent_ff;
   logic                  req_fire, rsp_fire, push, pop, beat_sample;

   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = (count_ff != 2'd2);

   always_comb begin
      logic [7:0]  b;
      logic        commit;
      logic [32:0] full;
      logic        pad;
      logic [2:0]  st;

      b = req_if.file_byte;
      commit = 1'b0;
      full = '0;
      pad = 1'b0;
      st = StatusOk;

      phase_in = phase_ff;
      hdr_index_in = hdr_index_ff;
      hdr_valid_in = hdr_valid_ff;
      riff_bad_in = riff_bad_ff;
      tag_in = tag_ff;
      size_in = size_ff;
      left_in = left_ff;
      first_in = first_ff;
      chunk_in = chunk_ff;
      win0_in = win0_ff;
      win1_in = win1_ff;
      chan_in = chan_ff;
      rate_in = rate_ff;
      bits_in = bits_ff;
      seen_fmt_in = seen_fmt_ff;
      seen_data_in = seen_data_ff;
      entry_in = '0;

      for (int k = 0; k < FmtLen - 1; k++) begin
         scratch_in[k] = scratch_ff[k+1];
      end
      scratch_in[FmtLen-1] = b;

      if (win0_ff != 5'd0) begin
         win0_in = win0_ff - 5'd1;
         if (win0_in == 5'd0) begin
            commit = 1'b1;
         end
      end
      if (win1_ff != 5'd0) begin
         win1_in = win1_ff - 5'd1;
         if (win1_in == 5'd0) begin
            commit = 1'b1;
         end
      end
      if (commit) begin
         chan_in = {scratch_in[3], scratch_in[2]};
         rate_in = {scratch_in[7], scratch_in[6], scratch_in[5], scratch_in[4]};
         bits_in = {scratch_in[15], scratch_in[14]};
         seen_fmt_in = 1'b1;
      end

      unique case (phase_ff)
         PhFileHdr: begin
            if (hdr_index_ff < 4'd4 && b != tag_char(TagRiff, hdr_index_ff[1:0])) begin
               riff_bad_in = 1'b1;
               hdr_valid_in = 1'b0;
            end
            if (hdr_index_ff >= 4'd8 && b != tag_char(TagWave, hdr_index_ff[1:0])) begin
               hdr_valid_in = 1'b0;
            end
            hdr_index_in = hdr_index_ff + 4'd1;
            if (hdr_index_in >= 4'(FileHdrLen)) begin
               hdr_index_in = '0;
               phase_in = hdr_valid_in ? PhChunkHdr : PhIgnore;
            end
         end
         PhChunkHdr: begin
            if (hdr_index_ff < 4'd4) begin
               tag_in = {tag_ff[23:0], b};
            end else begin
               size_in = {b, size_ff[31:8]};
            end
            hdr_index_in = hdr_index_ff + 4'd1;
            if (hdr_index_in >= 4'(ChunkHdrLen)) begin
               hdr_index_in = '0;
               if (tag_in == TagFmt) begin
                  chunk_in = ChunkFmt;
                  if (win0_in == 5'd0) begin
                     win0_in = FmtWin;
                  end else if (win1_in == 5'd0) begin
                     win1_in = FmtWin;
                  end else begin
                     win0_in = FmtWin;
                  end
               end else if (tag_in == TagData) begin
                  chunk_in = ChunkSamples;
                  seen_data_in = 1'b1;
               end else begin
                  chunk_in = ChunkOther;
               end
               full = {1'b0, size_in} + {32'd0, size_in[0]};
               left_in = full;
               first_in = 1'b1;
               phase_in = (full != '0) ? PhBody : PhChunkHdr;
            end
         end
         PhBody: begin
            pad = (left_ff == 33'd1) && size_ff[0];
            if (chunk_ff == ChunkSamples && !pad) begin
               entry_in.has_sample = 1'b1;
               entry_in.sample_byte = b;
               entry_in.run_start = first_ff;
            end
            first_in = 1'b0;
            left_in = left_ff - 33'd1;
            if (left_in == '0) begin
               phase_in = PhChunkHdr;
            end
         end
         default: begin
         end
      endcase

      if (req_if.end_of_file) begin
         priority if (phase_in == PhFileHdr) begin
            st = StatusShort;
         end else if (riff_bad_in) begin
            st = StatusNoRiff;
         end else if (!hdr_valid_in) begin
            st = StatusNoWave;
         end else if (!seen_fmt_in) begin
            st = StatusNoFmt;
         end else if (!seen_data_in) begin
            st = StatusNoData;
         end else begin
            st = StatusOk;
         end
         entry_in.has_summary = 1'b1;
         entry_in.parse_ok = (st == StatusOk);
         entry_in.status = st;
         entry_in.channel_count = chan_in;
         entry_in.sampling_hz = rate_in;
         entry_in.sample_bits = bits_in;

         phase_in = PhFileHdr;
         hdr_index_in = '0;
         hdr_valid_in = 1'b1;
         riff_bad_in = 1'b0;
         tag_in = '0;
         size_in = '0;
         left_in = '0;
         first_in = 1'b0;
         chunk_in = ChunkOther;
         win0_in = '0;
         win1_in = '0;
         chan_in = DefaultChannels;
         rate_in = DefaultRate;
         bits_in = DefaultBits;
         seen_fmt_in = 1'b0;
         seen_data_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhFileHdr;
         hdr_index_ff <= '0;
         hdr_valid_ff <= 1'b1;
         riff_bad_ff <= 1'b0;
         tag_ff <= '0;
         size_ff <= '0;
         left_ff <= '0;
         first_ff <= 1'b0;
         chunk_ff <= ChunkOther;
         win0_ff <= '0;
         win1_ff <= '0;
         chan_ff <= DefaultChannels;
         rate_ff <= DefaultRate;
         bits_ff <= DefaultBits;
         seen_fmt_ff <= 1'b0;
         seen_data_ff <= 1'b0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         hdr_index_ff <= hdr_index_in;
         hdr_valid_ff <= hdr_valid_in;
         riff_bad_ff <= riff_bad_in;
         tag_ff <= tag_in;
         size_ff <= size_in;
         left_ff <= left_in;
         first_ff <= first_in;
         chunk_ff <= chunk_in;
         win0_ff <= win0_in;
         win1_ff <= win1_in;
         chan_ff <= chan_in;
         rate_ff <= rate_in;
         bits_ff <= bits_in;
         seen_fmt_ff <= seen_fmt_in;
         seen_data_ff <= seen_data_in;
      end
   end

   // The fmt scratch bytes are always fully rewritten before a window commits.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         scratch_ff <= scratch_in;
      end
   end

   assign head = queue_ff[rd_ptr_ff];
   assign beat_sample = head.has_sample && !sent_ff;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;
   assign push = req_fire && (entry_in.has_sample || entry_in.has_summary);
   assign pop = rsp_fire && (!beat_sample || !head.has_summary);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff <= '0;
         sent_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            sent_ff <= 1'b0;
         end else if (rsp_fire) begin
            sent_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign rsp_if.valid = (count_ff != 2'd0);
   assign rsp_if.kind = beat_sample ? KindSample : KindSummary;
   assign rsp_if.sample_byte = beat_sample ? head.sample_byte : '0;
   assign rsp_if.run_start = beat_sample ? head.run_start : 1'b0;
   assign rsp_if.parse_ok = beat_sample ? 1'b0 : head.parse_ok;
   assign rsp_if.status = beat_sample ? StatusOk : head.status;
   assign rsp_if.channel_count = beat_sample ? '0 : head.channel_count;
   assign rsp_if.sampling_hz = beat_sample ? '0 : head.sampling_hz;
   assign rsp_if.sample_bits = beat_sample ? '0 : head.sample_bits;

endmodule
`default_nettype wire

@@ bench/riff_wave_chunk_parser_unit_checker.sv @@
module riff_wave_chunk_parser_unit_checker
   import rwcp_pkg::*;
(
   input  wire  clock,
   input  wire  reset,
   rwcp_req_if  req_mon,
   rwcp_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   samples_checked,
   output int   summaries_checked
);

   typedef enum logic [1:0] {
      PARSE_FILE_HDR,
      PARSE_CHUNK_HDR,
      PARSE_BODY,
      PARSE_IGNORE
   } parse_phase_type;

   typedef enum logic [1:0] {
      CHUNK_OTHER,
      CHUNK_FMT,
      CHUNK_SAMPLES
   } chunk_kind_type;

   typedef struct packed {
      logic                   kind;
      logic [ByteWidth-1:0]   sample_byte;
      logic                   run_start;
      logic                   parse_ok;
      logic [StatusWidth-1:0] status;
      logic [CountWidth-1:0]  channel_count;
      logic [RateWidth-1:0]   sampling_hz;
      logic [CountWidth-1:0]  sample_bits;
   } wav_rsp_type;

   parse_phase_type       phase;
   logic [3:0]            hdr_idx;
   logic                  hdr_good;
   logic                  riff_miss;
   logic [31:0]           tag_acc;
   logic [31:0]           size_acc;
   logic [32:0]           body_left;
   chunk_kind_type        chunk_type;
   logic [4:0]            fmt_win [2];
   logic [ByteWidth-1:0]  fmt_hist [FmtLen];
   logic [CountWidth-1:0] chan_held;
   logic [RateWidth-1:0]  rate_held;
   logic [CountWidth-1:0] bits_held;
   logic                  got_fmt;
   logic                  got_data;

   wav_rsp_type predicted_rsp [$];
   wav_rsp_type want;
   int          rsp_seen;

   task automatic clear_parser();
      int k;
      phase      = PARSE_FILE_HDR;
      hdr_idx    = '0;
      hdr_good   = 1'b1;
      riff_miss  = 1'b0;
      tag_acc    = '0;
      size_acc   = '0;
      body_left  = '0;
      chunk_type = CHUNK_OTHER;
      fmt_win[0] = '0;
      fmt_win[1] = '0;
      for (k = 0; k < FmtLen; k++) fmt_hist[k] = '0;
      chan_held  = DefaultChannels;
      rate_held  = DefaultRate;
      bits_held  = DefaultBits;
      got_fmt    = 1'b0;
      got_data   = 1'b0;
   endtask

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 40) begin
         $display("[%0t] MISMATCH rsp transaction %0d: %s", $realtime, rsp_seen, msg);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val) begin
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, exp_val));
      end
   endtask

   task automatic parse_wav_byte(input logic [7:0] b, input logic eof);
      int                     i;
      int                     w;
      logic [32:0]            full_len;
      logic                   is_pad;
      logic [StatusWidth-1:0] st;
      wav_rsp_type            r;
      for (i = 0; i < FmtLen - 1; i++) fmt_hist[i] = fmt_hist[i+1];
      fmt_hist[FmtLen-1] = b;
      for (w = 0; w < 2; w++) begin
         if (fmt_win[w] != 0) begin
            fmt_win[w] = fmt_win[w] - 5'd1;
            if (fmt_win[w] == 0) begin
               chan_held = {fmt_hist[3], fmt_hist[2]};
               rate_held = {fmt_hist[7], fmt_hist[6], fmt_hist[5], fmt_hist[4]};
               bits_held = {fmt_hist[15], fmt_hist[14]};
               got_fmt   = 1'b1;
            end
         end
      end

      case (phase)
         PARSE_FILE_HDR: begin
            i = int'(hdr_idx);
            if (i < 4 && b != TagRiff[31 - 8*(i & 3) -: 8]) begin
               riff_miss = 1'b1;
               hdr_good  = 1'b0;
            end
            if (i >= 8 && i < 12 && b != TagWave[31 - 8*(i & 3) -: 8]) hdr_good = 1'b0;
            hdr_idx = hdr_idx + 4'd1;
            if (hdr_idx >= FileHdrLen) begin
               hdr_idx = '0;
               phase   = hdr_good ? PARSE_CHUNK_HDR : PARSE_IGNORE;
            end
         end
         PARSE_CHUNK_HDR: begin
            if (hdr_idx < 4) tag_acc = {tag_acc[23:0], b};
            else size_acc = {b, size_acc[31:8]};
            hdr_idx = hdr_idx + 4'd1;
            if (hdr_idx >= ChunkHdrLen) begin
               hdr_idx = '0;
               if (tag_acc == TagFmt) begin
                  chunk_type = CHUNK_FMT;
                  if (fmt_win[0] == 0) fmt_win[0] = 5'(FmtLen);
                  else if (fmt_win[1] == 0) fmt_win[1] = 5'(FmtLen);
                  else fmt_win[0] = 5'(FmtLen);
               end else if (tag_acc == TagData) begin
                  chunk_type = CHUNK_SAMPLES;
                  got_data   = 1'b1;
               end else begin
                  chunk_type = CHUNK_OTHER;
               end
               body_left = {1'b0, size_acc} + {32'd0, size_acc[0]};
               phase     = (body_left != 0) ? PARSE_BODY : PARSE_CHUNK_HDR;
            end
         end
         PARSE_BODY: begin
            full_len = {1'b0, size_acc} + {32'd0, size_acc[0]};
            is_pad   = (body_left == 1) && size_acc[0];
            if (chunk_type == CHUNK_SAMPLES && !is_pad) begin
               r             = '0;
               r.kind        = KindSample;
               r.sample_byte = b;
               r.run_start   = (body_left == full_len);
               predicted_rsp.insert(predicted_rsp.size(), r);
            end
            if (body_left != 0) body_left = body_left - 33'd1;
            if (body_left == 0) phase = PARSE_CHUNK_HDR;
         end
         default: begin
         end
      endcase

      if (eof) begin
         if (phase == PARSE_FILE_HDR) st = StatusShort;
         else if (riff_miss) st = StatusNoRiff;
         else if (!hdr_good) st = StatusNoWave;
         else if (!got_fmt) st = StatusNoFmt;
         else if (!got_data) st = StatusNoData;
         else st = StatusOk;
         r               = '0;
         r.kind          = KindSummary;
         r.parse_ok      = (st == StatusOk);
         r.status        = st;
         r.channel_count = chan_held;
         r.sampling_hz   = rate_held;
         r.sample_bits   = bits_held;
         predicted_rsp.insert(predicted_rsp.size(), r);
         clear_parser();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         predicted_rsp.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_seen++;
            if (predicted_rsp.size() == 0) begin
               report_mismatch($sformatf("no result expected, got kind %0d", rsp_mon.kind));
            end else begin
               want = predicted_rsp.pop_front();
               check_field("kind", 32'(rsp_mon.kind), 32'(want.kind));
               check_field("sample_byte", 32'(rsp_mon.sample_byte), 32'(want.sample_byte));
               check_field("run_start", 32'(rsp_mon.run_start), 32'(want.run_start));
               check_field("parse_ok", 32'(rsp_mon.parse_ok), 32'(want.parse_ok));
               check_field("status", 32'(rsp_mon.status), 32'(want.status));
               check_field("channel_count", 32'(rsp_mon.channel_count),
                           32'(want.channel_count));
               check_field("sampling_hz", rsp_mon.sampling_hz, want.sampling_hz);
               check_field("sample_bits", 32'(rsp_mon.sample_bits), 32'(want.sample_bits));
               if (want.kind == KindSample) samples_checked++;
               else summaries_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_wav_byte(req_mon.file_byte, req_mon.end_of_file);
         end
      end
      pending <= predicted_rsp.size();
   end

endmodule

@@ bench/riff_wave_chunk_parser_unit_tb.sv @@
module riff_wave_chunk_parser_unit_tb;
   import rwcp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rwcp_req_if req_bus ();
   rwcp_rsp_if rsp_bus ();

   int  fail_count;
   int  pending;
   int  samples_checked;
   int  summaries_checked;
   int  files_built;
   int  long_stalls;
   bit  calm;
   bit  long_stall_req;

   logic [8:0] byte_stream [$];

   always #5 clock = ~clock;

   riff_wave_chunk_parser_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   riff_wave_chunk_parser_unit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .fail_count        (fail_count),
      .pending           (pending),
      .samples_checked   (samples_checked),
      .summaries_checked (summaries_checked)
   );

   task automatic add_byte(input logic [7:0] b);
      byte_stream.insert(byte_stream.size(), {1'b0, b});
   endtask

   task automatic add_tag(input logic [31:0] t);
      add_byte(t[31:24]);
      add_byte(t[23:16]);
      add_byte(t[15:8]);
      add_byte(t[7:0]);
   endtask

   task automatic add_le32(input logic [31:0] v);
      add_byte(v[7:0]);
      add_byte(v[15:8]);
      add_byte(v[23:16]);
      add_byte(v[31:24]);
   endtask

   task automatic end_file();
      logic [8:0] last;
      last = byte_stream.pop_back();
      byte_stream.insert(byte_stream.size(), {1'b1, last[7:0]});
      files_built++;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      int          i;
      int          n;
      int          roll;
      int          c;
      int          sz;
      int          file_start;
      int          file_len;
      int          cut;
      int          total;
      logic [31:0] riff_tag;
      logic [31:0] wave_tag;
      logic [31:0] tag;
      bit          do_cut;

      req_bus.valid       = 1'b0;
      req_bus.file_byte   = '0;
      req_bus.end_of_file = 1'b0;

      // Directed files: a lone byte, a header wrong in both tags, a bare good header.
      add_byte(8'hFF);
      end_file();
      add_tag(~TagRiff);
      add_le32(32'h0000_0000);
      add_tag(~TagWave);
      end_file();
      add_tag(TagRiff);
      add_le32(32'hFFFF_FFFF);
      add_tag(TagWave);
      end_file();

      while (byte_stream.size() < 1725) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            repeat ($urandom_range(1, 11)) add_byte(8'($urandom_range(0, 255)));
            end_file();
            continue;
         end
         riff_tag = TagRiff;
         wave_tag = TagWave;
         if (roll < 10) riff_tag[$urandom_range(0, 31)] ^= 1'b1;
         if (roll >= 7 && roll < 16) wave_tag[$urandom_range(0, 31)] ^= 1'b1;
         file_start = byte_stream.size();
         add_tag(riff_tag);
         add_le32($urandom);
         add_tag(wave_tag);
         if (roll < 16) begin
            repeat ($urandom_range(0, 30)) add_byte(8'($urandom_range(0, 255)));
            end_file();
            continue;
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(2, 3)) begin
               add_tag(TagFmt);
               add_le32(32'd0);
            end
         end
         n = $urandom_range(0, 5);
         for (i = 0; i < n; i++) begin
            c = $urandom_range(0, 99);
            if (c < 35) begin
               roll = $urandom_range(0, 99);
               if (roll < 60) sz = 16;
               else if (roll < 75) sz = 18;
               else if (roll < 90) sz = $urandom_range(0, 6);
               else sz = $urandom_range(0, 40);
               add_tag(TagFmt);
            end else if (c < 70) begin
               add_tag(TagData);
               if ($urandom_range(0, 15) == 0) begin
                  add_le32($urandom | 32'h0000_0100);
                  repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
                  break;
               end
               sz = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            end else begin
               if (c < 80) tag = 32'h4C49_5354;
               else if (c < 90) begin
                  tag = (c < 85) ? TagFmt : TagData;
                  tag[$urandom_range(0, 31)] ^= 1'b1;
               end else tag = $urandom;
               add_tag(tag);
               sz = $urandom_range(0, 12);
            end
            add_le32(32'(sz));
            repeat (sz) add_byte(8'($urandom_range(0, 255)));
            if (sz % 2 == 1) add_byte(8'($urandom_range(0, 255)));
         end
         do_cut = ($urandom_range(0, 99) < 15);
         if (do_cut) begin
            file_len = byte_stream.size() - file_start;
            cut = $urandom_range(1, (file_len > 24) ? 24 : file_len - 1);
            repeat (cut) void'(byte_stream.pop_back());
         end
         end_file();
      end

      total = byte_stream.size();
      @(negedge clock);
      while (reset) @(negedge clock);
      for (i = 0; i < total; i++) begin
         if (i == 300 || i == 1100) long_stall_req = 1'b1;
         if (i >= total - 150) calm = 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         req_bus.valid       <= 1'b1;
         req_bus.file_byte   <= byte_stream[i][7:0];
         req_bus.end_of_file <= byte_stream[i][8];
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         @(negedge clock);
      end
      req_bus.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d files in %0d bytes, %0d long receiver stalls.",
               files_built, total, long_stalls);
      $display("Checked %0d sample and %0d summary transactions.",
               samples_checked, summaries_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      int stall_cnt;
      rsp_bus.ready = 1'b0;
      stall_cnt     = 0;
      forever begin
         @(negedge clock);
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            long_stalls++;
            stall_cnt = 250;
         end
         if (stall_cnt > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_cnt--;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_cnt = $urandom_range(1, 6) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding.", pending);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
